@@ rtl/core/servo_status_packet_parser_unit_macros.svh @@
// Assertion macros for the servo status packet parser checker.
// Used by the checker file only; no dependencies.
`ifndef SERVO_STATUS_PACKET_PARSER_UNIT_MACROS_SVH
`define SERVO_STATUS_PACKET_PARSER_UNIT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define SSPP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define SSPP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/sspp_pkg.sv @@
// Shared types and constants for the servo status packet parser.
// No dependencies; imported by every other RTL file but sspp_if and the macro header.
`default_nettype none

package sspp_pkg;

  localparam logic [7:0] START_BYTE     = 8'hFF;
  localparam logic [7:0] MIN_LENGTH     = 8'd2;
  localparam logic [7:0] MAX_PARAMS_RST = 8'd2;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Register index taken from paddr[2].
  localparam logic REG_MAX_PARAMS = 1'b0;

  typedef struct packed {
    logic       kind;
    logic [7:0] param_byte;
    logic [7:0] param_index;
    logic [7:0] servo_id;
    logic [7:0] status_error;
    logic       checksum_ok;
    logic       frame_error;
  } res_t;

  localparam logic KIND_PARAM = 1'b0;
  localparam logic KIND_END   = 1'b1;

endpackage

`default_nettype wire

@@ rtl/core/sspp_if.sv @@
// Valid/ready channel interfaces for received bytes and parser results.
// Depends on nothing; used by the top level and its environment.
`default_nettype none

interface sspp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sspp_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] param_byte;
  logic [7:0] param_index;
  logic [7:0] servo_id;
  logic [7:0] status_error;
  logic       checksum_ok;
  logic       frame_error;

  modport source (output valid, output kind, output param_byte, output param_index,
                  output servo_id, output status_error, output checksum_ok,
                  output frame_error, input ready);
  modport sink (input valid, input kind, input param_byte, input param_index,
                input servo_id, input status_error, input checksum_ok,
                input frame_error, output ready);
endinterface

`default_nettype wire

@@ rtl/core/servo_status_packet_parser_unit.sv @@
// Servo status packet parser. One received byte is taken per beat on in_ch and
// the packet state is advanced in a single registered pass, so a new byte can be
// accepted every clock cycle while no result is held back. A byte accepted into
// the input register is parsed from there, and any result it produces is loaded
// into the output register, from which it shows on out_ch. Throughput is one
// byte per cycle, set by the parse stage and its state registers, as long as
// out_ch is ready. While a result waits in the output register, a byte that
// produces another result waits in the input register and holds back the input;
// bytes that produce no result keep flowing.
// Depends on sspp_pkg, sspp_if, sspp_cfg, sspp_parse and sspp_out_reg.
`default_nettype none

module servo_status_packet_parser_unit
  import sspp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  sspp_in_if.sink                 in_ch,
  sspp_out_if.source              out_ch,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  logic [7:0] max_params;
  logic       slot_free;
  logic       res_valid;
  res_t       res;
  res_t       out_res;

  sspp_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .max_params (max_params)
  );

  sspp_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_byte    (in_ch.rx_byte),
    .max_params (max_params),
    .slot_free  (slot_free),
    .res_valid  (res_valid),
    .res        (res)
  );

  sspp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .slot_free (slot_free),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.kind         = out_res.kind;
  assign out_ch.param_byte   = out_res.param_byte;
  assign out_ch.param_index  = out_res.param_index;
  assign out_ch.servo_id     = out_res.servo_id;
  assign out_ch.status_error = out_res.status_error;
  assign out_ch.checksum_ok  = out_res.checksum_ok;
  assign out_ch.frame_error  = out_res.frame_error;

endmodule

`default_nettype wire

@@ rtl/core/sspp_cfg.sv @@
// APB-style register file holding the max_params limit.
// Depends on sspp_pkg.
`default_nettype none

module sspp_cfg
  import sspp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output logic      [7:0]         max_params
);

  logic [7:0] max_params_r;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_params_r <= MAX_PARAMS_RST;
    end else if (wr_en && (paddr[2] == REG_MAX_PARAMS)) begin
      max_params_r <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_MAX_PARAMS: prdata = {{(PDATA_W-8){1'b0}}, max_params_r};
      default:        prdata = '0;
    endcase
  end

  assign max_params = max_params_r;

endmodule

`default_nettype wire

@@ rtl/core/sspp_parse.sv @@
// Input byte register, packet state machine and result formation.
// Depends on sspp_pkg; feeds the result register.
`default_nettype none

module sspp_parse
  import sspp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic [7:0] max_params,
  input  wire logic       slot_free,
  output logic            res_valid,
  output res_t            res
);

  typedef enum logic [2:0] {
    PH_HUNT1, PH_HUNT2, PH_ID, PH_LEN, PH_ERR, PH_PARAM, PH_CSUM
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic       in_v_r, in_v_nxt;
  logic [7:0] in_byte_r;
  logic [7:0] packet_id_r, packet_id_nxt;
  logic [7:0] packet_length_r, packet_length_nxt;
  logic [7:0] error_byte_r, error_byte_nxt;
  logic [7:0] param_count_r, param_count_nxt;
  logic [7:0] running_sum_r, running_sum_nxt;
  logic       emit;
  logic       adv;
  logic       in_fire;
  logic [7:0] count_inc;
  logic [7:0] sum_add;

  assign count_inc = param_count_r + 8'd1;
  assign sum_add   = running_sum_r + in_byte_r;

  always_comb begin
    phase_nxt         = phase_r;
    packet_id_nxt     = packet_id_r;
    packet_length_nxt = packet_length_r;
    error_byte_nxt    = error_byte_r;
    param_count_nxt   = param_count_r;
    running_sum_nxt   = running_sum_r;
    emit              = 1'b0;
    res               = '0;
    unique case (phase_r)
      PH_HUNT2: begin
        phase_nxt = (in_byte_r == START_BYTE) ? PH_ID : PH_HUNT1;
      end
      PH_ID: begin
        if (in_byte_r == START_BYTE) begin
          phase_nxt       = PH_HUNT1;
          emit            = 1'b1;
          res.kind        = KIND_END;
          res.frame_error = 1'b1;
        end else begin
          packet_id_nxt   = in_byte_r;
          running_sum_nxt = in_byte_r;
          phase_nxt       = PH_LEN;
        end
      end
      PH_LEN: begin
        if ((in_byte_r < MIN_LENGTH) || ((in_byte_r - MIN_LENGTH) > max_params)) begin
          phase_nxt       = PH_HUNT1;
          emit            = 1'b1;
          res.kind        = KIND_END;
          res.servo_id    = packet_id_r;
          res.frame_error = 1'b1;
        end else begin
          packet_length_nxt = in_byte_r;
          running_sum_nxt   = sum_add;
          phase_nxt         = PH_ERR;
        end
      end
      PH_ERR: begin
        error_byte_nxt  = in_byte_r;
        running_sum_nxt = sum_add;
        param_count_nxt = '0;
        phase_nxt       = (packet_length_r == MIN_LENGTH) ? PH_CSUM : PH_PARAM;
      end
      PH_PARAM: begin
        running_sum_nxt  = sum_add;
        param_count_nxt  = count_inc;
        if (count_inc >= (packet_length_r - MIN_LENGTH)) begin
          phase_nxt = PH_CSUM;
        end
        emit             = 1'b1;
        res.kind         = KIND_PARAM;
        res.param_byte   = in_byte_r;
        res.param_index  = param_count_r;
        res.servo_id     = packet_id_r;
        res.status_error = error_byte_r;
      end
      PH_CSUM: begin
        phase_nxt        = PH_HUNT1;
        emit             = 1'b1;
        res.kind         = KIND_END;
        res.servo_id     = packet_id_r;
        res.status_error = error_byte_r;
        res.checksum_ok  = (~running_sum_r == in_byte_r);
      end
      default: begin
        // Hunting the first start byte; the unused phase code lands here too.
        phase_nxt = (in_byte_r == START_BYTE) ? PH_HUNT2 : PH_HUNT1;
      end
    endcase
  end

  // A byte that yields a result waits until the result register has room.
  assign adv       = in_v_r && (!emit || slot_free);
  assign res_valid = in_v_r && emit && slot_free;
  assign in_ready  = !in_v_r || adv;
  assign in_fire   = in_valid && in_ready;

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_fire) begin
      in_v_nxt = 1'b1;
    end else if (adv) begin
      in_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r          <= 1'b0;
      phase_r         <= PH_HUNT1;
      packet_id_r     <= '0;
      packet_length_r <= '0;
      error_byte_r    <= '0;
      param_count_r   <= '0;
      running_sum_r   <= '0;
    end else begin
      in_v_r <= in_v_nxt;
      if (adv) begin
        phase_r         <= phase_nxt;
        packet_id_r     <= packet_id_nxt;
        packet_length_r <= packet_length_nxt;
        error_byte_r    <= error_byte_nxt;
        param_count_r   <= param_count_nxt;
        running_sum_r   <= running_sum_nxt;
      end
    end
    if (in_fire) begin
      in_byte_r <= in_byte;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/sspp_out_reg.sv @@
// Result register between the parser logic and the output channel.
// Depends on sspp_pkg.
`default_nettype none

module sspp_out_reg
  import sspp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic res_valid,
  input  res_t      res,
  output logic      slot_free,
  output logic      out_valid,
  input  wire logic out_ready,
  output res_t      out_res
);

  logic out_v_r;
  res_t out_res_r;

  assign slot_free = !out_v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (res_valid) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
    if (res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid = out_v_r;
  assign out_res   = out_res_r;

endmodule

`default_nettype wire

@@ rtl/core/sspp_checker.sv @@
// Port-level checker for the servo status packet parser, bound to the top level.
// Depends on sspp_pkg and the assertion macro header.
`default_nettype none
`include "servo_status_packet_parser_unit_macros.svh"

module sspp_checker
  import sspp_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       kind,
  input wire logic [7:0] param_byte,
  input wire logic [7:0] param_index,
  input wire logic [7:0] status_error,
  input wire logic       checksum_ok,
  input wire logic       frame_error,
  input wire logic       pready
);

  logic        param_beat;
  logic        verdict_set;
  logic        ferr_beat;
  logic        body_clear;
  logic        out_stall;
  logic [16:0] beat_fields;

  assign param_beat  = out_valid && (kind == KIND_PARAM);
  assign verdict_set = checksum_ok || frame_error;
  assign ferr_beat   = out_valid && frame_error;
  assign body_clear  = (kind == KIND_END) && !checksum_ok && (status_error == 8'd0)
                       && (param_byte == 8'd0) && (param_index == 8'd0);
  assign out_stall   = out_valid && !out_ready;
  assign beat_fields = {kind, param_byte, param_index};

  // A parameter beat never carries an end verdict.
  `SSPP_ASSERT(a_param_no_verdict, param_beat |-> !verdict_set, "parameter beat has a verdict")

  // A frame error beat is an end beat with the packet body fields cleared.
  `SSPP_ASSERT(a_frame_err_clean, ferr_beat |-> body_clear, "frame error beat has stray fields")

  // No result can be shown in the cycle right after reset.
  `SSPP_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid, "result valid right after reset")

  // A stalled result beat stays valid with its kind, parameter byte and index unchanged.
  `SSPP_ASSERT(a_out_hold, out_stall |=> (out_valid && $stable(beat_fields)), "stalled beat changed")

  `SSPP_ASSERT_ALWAYS(a_pready_high, pready, "pready dropped")

endmodule

bind servo_status_packet_parser_unit sspp_checker u_sspp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .kind         (out_ch.kind),
  .param_byte   (out_ch.param_byte),
  .param_index  (out_ch.param_index),
  .status_error (out_ch.status_error),
  .checksum_ok  (out_ch.checksum_ok),
  .frame_error  (out_ch.frame_error),
  .pready       (pready)
);

`default_nettype wire

@@ verif/servo_status_packet_parser_unit_tb.sv @@
// Self-checking testbench for the servo status packet parser.
// Depends on sspp_pkg, the sspp_in_if/sspp_out_if channels and the parser top level.
// A parser model or directed table predicts each result; random bursts and stalls load both sides.
module servo_status_packet_parser_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sspp_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int MAX_REPORTS    = 10;
  localparam logic [PADDR_W-1:0] ADDR_MAX_PARAMS = {REG_MAX_PARAMS, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_SPARE      = {~REG_MAX_PARAMS, 2'b00};

  typedef enum logic [2:0] {
    HUNT_FIRST, HUNT_SECOND, GET_ID, GET_LEN, GET_ERR, GET_PARAM, GET_CSUM
  } parse_phase_t;

  typedef enum int {NOISE, LONE_START, BAD_ID, SHORT_LEN, LONG_LEN, CUT_SHORT} fault_t;
  typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} stall_t;

  typedef struct packed {
    logic [7:0] rx;
    logic       typed;
    res_t       res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel, penable, pwrite, pready;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata, prdata;

  sspp_in_if  in_ch();
  sspp_out_if out_ch();

  servo_status_packet_parser_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #5 clk = ~clk;

  // Parser model state and its copy of the register.
  parse_phase_t ph = HUNT_FIRST;
  logic [7:0] cur_id = '0, cur_len = '0, cur_err = '0, cur_count = '0, cur_sum = '0;
  logic [7:0] cfg_max_params = MAX_PARAMS_RST;

  res_t expected_q[$];
  dir_row_t directed_tbl[$];
  logic row_typed = 1'b0;
  res_t row_res = '0;
  int n_mismatch = 0;
  int n_sent = 0;
  int burst_left = 0;
  int stuck_cycles = 0;
  stall_t ready_mode = RX_OPEN;
  int mode_left = 0;

  function automatic res_t end_result(logic [7:0] id, logic [7:0] err, logic ok, logic ferr);
    res_t r;
    r = '0;
    r.kind = KIND_END;
    r.servo_id = id;
    r.status_error = err;
    r.checksum_ok = ok;
    r.frame_error = ferr;
    return r;
  endfunction

  // Advances the model by one byte; returns 1 when the byte produces a result beat.
  function automatic bit parse_byte(input logic [7:0] c, output res_t r);
    bit emit;
    logic [7:0] want_csum;
    emit = 1'b0;
    r = '0;
    case (ph)
      HUNT_SECOND: begin
        ph = (c == START_BYTE) ? GET_ID : HUNT_FIRST;
      end
      GET_ID: begin
        if (c == START_BYTE) begin
          ph = HUNT_FIRST;
          r = end_result(8'h00, 8'h00, 1'b0, 1'b1);
          emit = 1'b1;
        end else begin
          cur_id = c;
          cur_sum = c;
          ph = GET_LEN;
        end
      end
      GET_LEN: begin
        if (c < MIN_LENGTH || (c - MIN_LENGTH) > cfg_max_params) begin
          ph = HUNT_FIRST;
          r = end_result(cur_id, 8'h00, 1'b0, 1'b1);
          emit = 1'b1;
        end else begin
          cur_len = c;
          cur_sum = cur_sum + c;
          ph = GET_ERR;
        end
      end
      GET_ERR: begin
        cur_err = c;
        cur_sum = cur_sum + c;
        cur_count = '0;
        ph = (cur_len == MIN_LENGTH) ? GET_CSUM : GET_PARAM;
      end
      GET_PARAM: begin
        r.kind = KIND_PARAM;
        r.param_byte = c;
        r.param_index = cur_count;
        r.servo_id = cur_id;
        r.status_error = cur_err;
        emit = 1'b1;
        cur_sum = cur_sum + c;
        cur_count = cur_count + 8'd1;
        if (cur_count >= cur_len - MIN_LENGTH) ph = GET_CSUM;
      end
      GET_CSUM: begin
        want_csum = ~cur_sum;
        ph = HUNT_FIRST;
        r = end_result(cur_id, cur_err, want_csum == c, 1'b0);
        emit = 1'b1;
      end
      default: begin
        ph = (c == START_BYTE) ? HUNT_SECOND : HUNT_FIRST;
      end
    endcase
    return emit;
  endfunction

  function automatic string fmt_res(res_t r);
    return $sformatf("kind=%0d byte=%02h index=%0d id=%02h err=%02h ok=%0d ferr=%0d",
                     r.kind, r.param_byte, r.param_index, r.servo_id, r.status_error,
                     r.checksum_ok, r.frame_error);
  endfunction

  task automatic note_error(input string msg);
    n_mismatch++;
    if (n_mismatch <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
  endtask

  // Result checking first, then the input beat of the same edge feeds the model.
  always @(posedge clk) begin
    res_t got, want, pred;
    bit emits;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.kind = out_ch.kind;
        got.param_byte = out_ch.param_byte;
        got.param_index = out_ch.param_index;
        got.servo_id = out_ch.servo_id;
        got.status_error = out_ch.status_error;
        got.checksum_ok = out_ch.checksum_ok;
        got.frame_error = out_ch.frame_error;
        if (expected_q.size() == 0) begin
          note_error({"unexpected result beat: ", fmt_res(got)});
        end else begin
          want = expected_q.pop_front();
          if (got !== want)
            note_error({"result mismatch: expected ", fmt_res(want), " got ", fmt_res(got)});
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        emits = parse_byte(in_ch.rx_byte, pred);
        if (row_typed) expected_q.push_back(row_res);
        else if (emits) expected_q.push_back(pred);
      end
    end
  end

  // Receiver stalls follow a randomly drawn mode, redrawn when its countdown runs out.
  always @(posedge clk) begin
    if (mode_left == 0) begin
      ready_mode = stall_t'($urandom_range(0, 3));
      mode_left = $urandom_range(20, 200);
    end else begin
      mode_left--;
    end
    case (ready_mode)
      RX_OPEN:  out_ch.ready <= 1'b1;
      RX_LIGHT: out_ch.ready <= ($urandom_range(0, 3) != 0);
      RX_HEAVY: out_ch.ready <= ($urandom_range(0, 7) == 0);
      default:  out_ch.ready <= ((mode_left % 5) < 3);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
        stuck_cycles = 0;
      else
        stuck_cycles++;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("servo_status_packet_parser_unit_tb: done, errors");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic typed = 1'b0,
                           input res_t tres = '0);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.rx_byte <= b;
    row_typed <= typed;
    row_res <= tres;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n_sent++;
  endtask

  // Holds the sender until every pending result has come and the pipeline is empty.
  // The first edge lets the monitor log the last accepted beat before the queue is read.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr[2] == REG_MAX_PARAMS) cfg_max_params = data[7:0];
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_max_params();
    logic [PDATA_W-1:0] d;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_MAX_PARAMS;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    d = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (d[7:0] !== cfg_max_params)
      note_error($sformatf("max_params read back %02h, expected %02h", d[7:0], cfg_max_params));
  endtask

  task automatic set_max_params(input logic [7:0] v);
    wait_idle();
    apb_write(ADDR_MAX_PARAMS, {8'($urandom_range(0, 255)), 16'h0000, v});
    check_max_params();
  endtask

  // Mostly short parameter lists, now and then anything up to the limit.
  function automatic int pick_count();
    int top;
    top = (cfg_max_params < 6) ? cfg_max_params : 6;
    if ($urandom_range(0, 19) != 0) return $urandom_range(0, top);
    return $urandom_range(0, cfg_max_params);
  endfunction

  task automatic send_packet(input int n, input bit good_csum);
    logic [7:0] id, err, len, sum, b;
    id = 8'($urandom_range(0, 8'hFE));
    err = 8'($urandom_range(0, 255));
    len = 8'(n) + MIN_LENGTH;
    sum = id + len + err;
    send_byte(START_BYTE);
    send_byte(START_BYTE);
    send_byte(id);
    send_byte(len);
    send_byte(err);
    repeat (n) begin
      b = 8'($urandom_range(0, 255));
      sum = sum + b;
      send_byte(b);
    end
    send_byte(good_csum ? ~sum : 8'($urandom_range(0, 255)));
  endtask

  task automatic send_broken();
    fault_t f;
    int n;
    f = fault_t'($urandom_range(0, 5));
    if (f != NOISE) send_byte(START_BYTE);
    if (f != NOISE && f != LONE_START) send_byte(START_BYTE);
    case (f)
      NOISE:      repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
      LONE_START: send_byte(8'($urandom_range(0, 8'hFE)));
      BAD_ID:     send_byte(START_BYTE);
      SHORT_LEN: begin
        send_byte(8'($urandom_range(0, 8'hFE)));
        send_byte(8'($urandom_range(0, 1)));
      end
      LONG_LEN: begin
        send_byte(8'($urandom_range(0, 8'hFE)));
        if (cfg_max_params <= 8'd252)
          send_byte(8'($urandom_range(int'(cfg_max_params) + 3, 255)));
        else
          send_byte(8'($urandom_range(0, 1)));
      end
      default: begin
        // Packet cut off part way; the next bytes land in the wrong fields.
        n = pick_count();
        send_byte(8'($urandom_range(0, 8'hFE)));
        send_byte(8'(n) + MIN_LENGTH);
        if (n > 0) begin
          send_byte(8'($urandom_range(0, 255)));
          repeat ($urandom_range(0, n - 1)) send_byte(8'($urandom_range(0, 255)));
        end
      end
    endcase
  endtask

  task automatic run_random(input int items);
    int stop;
    stop = n_sent + items;
    while (n_sent < stop) begin
      if ($urandom_range(0, 9) < 8) send_packet(pick_count(), $urandom_range(0, 7) != 0);
      else send_broken();
      if ($urandom_range(0, 59) == 0) wait_idle();
    end
  endtask

  function automatic dir_row_t pass_row(logic [7:0] b);
    dir_row_t r;
    r = '0;
    r.rx = b;
    return r;
  endfunction

  function automatic dir_row_t end_row(logic [7:0] b, logic [7:0] id, logic [7:0] err,
                                       logic ok, logic ferr);
    dir_row_t r;
    r.rx = b;
    r.typed = 1'b1;
    r.res = end_result(id, err, ok, ferr);
    return r;
  endfunction

  initial begin
    in_ch.valid = 1'b0;
    in_ch.rx_byte = '0;
    out_ch.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;

    directed_tbl = '{
      // Two parameters with a correct checksum.
      pass_row(8'hFF), pass_row(8'hFF), pass_row(8'h01), pass_row(8'h04),
      pass_row(8'h00), pass_row(8'hAA), pass_row(8'h55),
      end_row(8'hFB, 8'h01, 8'h00, 1'b1, 1'b0),
      // Highest id, no parameters, all-ones error byte; the right checksum would be 00.
      pass_row(8'hFF), pass_row(8'hFF), pass_row(8'hFE), pass_row(8'h02),
      pass_row(8'hFF), end_row(8'h01, 8'hFE, 8'hFF, 1'b0, 1'b0),
      // Id equal to the start byte.
      pass_row(8'hFF), pass_row(8'hFF), end_row(8'hFF, 8'h00, 8'h00, 1'b0, 1'b1),
      // Zero length.
      pass_row(8'hFF), pass_row(8'hFF), pass_row(8'h07),
      end_row(8'h00, 8'h07, 8'h00, 1'b0, 1'b1),
      // Three parameters against the reset limit of two.
      pass_row(8'hFF), pass_row(8'hFF), pass_row(8'h05),
      end_row(8'h05, 8'h05, 8'h00, 1'b0, 1'b1),
      // A start byte followed by something else is dropped silently.
      pass_row(8'hFF), pass_row(8'h00)
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    check_max_params();
    foreach (directed_tbl[i])
      send_byte(directed_tbl[i].rx, directed_tbl[i].typed, directed_tbl[i].res);
    wait_idle();
    run_random(80);

    set_max_params(8'd0);
    run_random(70);

    set_max_params(8'd253);
    send_packet(253, 1'b1);
    run_random(60);

    // The unused register slot must leave the limit untouched.
    wait_idle();
    apb_write(ADDR_SPARE, $urandom());
    check_max_params();

    set_max_params(8'($urandom_range(1, 252)));
    run_random(80);

    set_max_params(8'd1);
    run_random(70);

    wait_idle();
    repeat (10) @(posedge clk);
    if (n_mismatch == 0 && expected_q.size() == 0)
      $display("servo_status_packet_parser_unit_tb: done, clean");
    else
      $display("servo_status_packet_parser_unit_tb: done, errors");
    $finish;
  end

endmodule
